FILE: src/lpcd_pkg.sv
// Package: constants, command codes, state encoding and result type.
`timescale 1ns / 1ps
package lpcd_pkg;

  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(Slots + 1);

  typedef enum logic [2:0] {
    CMD_GET       = 3'd0,
    CMD_PUT       = 3'd1,
    CMD_FLUSH_PG  = 3'd2,
    CMD_FLUSH_ALL = 3'd3,
    CMD_MARK      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TOUCH,
    ST_FLUSH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        found;
    logic        fill_needed;
    logic        writeback_valid;
    logic [31:0] writeback_page;
    logic [3:0]  writeback_slot;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] page_number;
  } cmd_t;

endpackage

FILE: src/lpcd_if.sv
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface lpcd_cmd_if;
  logic           valid;
  logic           ready;
  lpcd_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpcd_res_if;
  logic              valid;
  logic              ready;
  lpcd_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/lru_page_cache_directory.sv
// Top level: LRU page cache directory with a one-slot-per-cycle scan sequencer.
`timescale 1ns / 1ps
//  channel   dir  type         transfer when
//  cmd       in   lpcd_cmd_if  cmd.valid & cmd.ready
//  res       out  lpcd_res_if  res.valid & res.ready
//
// Each command but flush all walks all slots one per cycle through one shared
// page compare (SCAN); for get/put a second walk (TOUCH) then updates recency
// ranks. States: get/put IDLE, SCAN, DECIDE, TOUCH, OUT; flush page, mark
// dirty, unknown codes IDLE, SCAN, DECIDE, OUT; flush all IDLE, FLUSH, OUT.
// Flush all emits one result per valid dirty slot (an empty one if none).
// Results wait in a single output register; a held result stalls flush all
// mid-walk and every other command at its final step.
// Reset clears valid, dirty, ranks and counters; page tags need no reset.
module lru_page_cache_directory (
  input  logic             clk_i,
  input  logic             rst_ni,
  lpcd_cmd_if.sink         cmd,
  lpcd_res_if.source       res
);

  localparam int unsigned SW = lpcd_pkg::SlotW;
  localparam int unsigned N  = lpcd_pkg::Slots;

  lpcd_pkg::state_e state_q, state_d;

  logic [31:0]  page_mem [N];   // tag store, read at scan index
  logic [N-1:0] valid_q, dirty_q;
  logic [SW-1:0] rank_q [N];
  logic [31:0]  hits_q, miss_q;

  logic [2:0]    cmd_q;
  logic [31:0]  pg_q;
  logic [SW:0]   idx_q;          // walk index, one bit wider than a slot index
  logic          match_q;
  logic [SW-1:0] match_s_q;
  logic          free_q;
  logic [SW-1:0] free_s_q;
  logic [SW-1:0] lru_s_q;
  logic [SW-1:0] lru_r_q;
  logic [lpcd_pkg::CntW-1:0] vcnt_q;
  logic [SW-1:0] tgt_q;          // slot being touched
  logic [lpcd_pkg::CntW-1:0] old_q;  // its old rank (or valid count)
  logic          any_q;

  lpcd_pkg::result_t out_q, out_d;
  logic              ovld_q, ovld_d;
  lpcd_pkg::result_t pend_q, pend_d;   // result staged at DECIDE / FLUSH
  lpcd_pkg::result_t dec_res, fa_res;

  logic [SW-1:0] ix;
  logic          cur_v, cur_match;
  assign ix        = idx_q[SW-1:0];
  assign cur_v     = valid_q[ix];
  assign cur_match = cur_v && (page_mem[ix] == pg_q);

  logic walk_end;
  assign walk_end = (idx_q[SW-1:0] == SW'(N - 1));
  logic is_gp;
  assign is_gp = (cmd_q == lpcd_pkg::CMD_GET) || (cmd_q == lpcd_pkg::CMD_PUT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpcd_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.data.command == lpcd_pkg::CMD_FLUSH_ALL) state_d = lpcd_pkg::ST_FLUSH;
          else state_d = lpcd_pkg::ST_SCAN;
        end
      end
      lpcd_pkg::ST_SCAN:   if (walk_end) state_d = lpcd_pkg::ST_DECIDE;
      lpcd_pkg::ST_DECIDE: state_d = is_gp ? lpcd_pkg::ST_TOUCH : lpcd_pkg::ST_OUT;
      lpcd_pkg::ST_TOUCH:  if (walk_end) state_d = lpcd_pkg::ST_OUT;
      lpcd_pkg::ST_FLUSH: begin
        if (!(ovld_q && !res.ready) && walk_end) state_d = lpcd_pkg::ST_OUT;
      end
      lpcd_pkg::ST_OUT: begin
        if (!ovld_q || res.ready) state_d = lpcd_pkg::ST_IDLE;
      end
      default: state_d = lpcd_pkg::ST_IDLE;
    endcase
  end

  // port outputs
  always_comb begin
    cmd.ready = (state_q == lpcd_pkg::ST_IDLE);
    res.valid = ovld_q;
    res.data  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lpcd_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  logic [SW-1:0] vic;
  always_comb begin
    vic = free_q ? free_s_q : lru_s_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lpcd_pkg::ST_DECIDE && is_gp && !match_q)
      page_mem[vic] <= pg_q;
  end

  logic fa_emit;
  assign fa_emit = (state_q == lpcd_pkg::ST_FLUSH) && !(ovld_q && !res.ready)
                   && cur_v && dirty_q[ix];

  // result of get/put/flush page/mark dirty (blank for other codes), built from scan outcome
  always_comb begin
    dec_res      = '0;
    dec_res.last = 1'b1;
    if (is_gp) begin
      if (match_q) begin
        dec_res.hit  = 1'b1;
        dec_res.slot = 4'(match_s_q);
      end else begin
        dec_res.slot        = 4'(vic);
        dec_res.fill_needed = (cmd_q == lpcd_pkg::CMD_GET);
        if (!free_q && dirty_q[vic]) begin
          dec_res.writeback_valid = 1'b1;
          dec_res.writeback_page  = page_mem[vic];
          dec_res.writeback_slot  = 4'(vic);
        end
      end
    end else if ((cmd_q == lpcd_pkg::CMD_FLUSH_PG || cmd_q == lpcd_pkg::CMD_MARK)
                 && match_q) begin
      dec_res.found = 1'b1;
      dec_res.slot  = 4'(match_s_q);
      if (cmd_q == lpcd_pkg::CMD_FLUSH_PG && dirty_q[match_s_q]) begin
        dec_res.writeback_valid = 1'b1;
        dec_res.writeback_page  = pg_q;
        dec_res.writeback_slot  = 4'(match_s_q);
      end
    end
  end

  // flush all write-back for the slot under the walk index
  always_comb begin
    fa_res                 = '0;
    fa_res.slot            = 4'(ix);
    fa_res.writeback_valid = 1'b1;
    fa_res.writeback_page  = page_mem[ix];
    fa_res.writeback_slot  = 4'(ix);
  end

  // output register and staged result; flush all lags one dirty slot behind
  // so that the final one can carry last
  always_comb begin
    ovld_d = ovld_q && !res.ready;
    out_d  = out_q;
    pend_d = pend_q;
    case (state_q)
      lpcd_pkg::ST_DECIDE: pend_d = dec_res;
      lpcd_pkg::ST_FLUSH: begin
        if (fa_emit) begin
          if (any_q) begin
            ovld_d           = 1'b1;
            out_d            = pend_q;
            out_d.hit_count  = hits_q;
            out_d.miss_count = miss_q;
            out_d.last       = 1'b0;
          end
          pend_d = fa_res;
        end else if (idx_q == '0) pend_d = '0;
      end
      lpcd_pkg::ST_OUT: begin
        if (!ovld_q || res.ready) begin
          ovld_d           = 1'b1;
          out_d            = pend_q;
          out_d.last       = 1'b1;
          out_d.hit_count  = hits_q;
          out_d.miss_count = miss_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      out_q  <= '0;
      pend_q <= '0;
    end else begin
      ovld_q <= ovld_d;
      out_q  <= out_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      dirty_q   <= '0;
      for (int i = 0; i < N; i++) rank_q[i] <= '0;
      hits_q    <= '0;
      miss_q    <= '0;
      idx_q     <= '0;
      any_q     <= 1'b0;
      cmd_q     <= '0;
      pg_q      <= '0;
      match_q   <= 1'b0;
      match_s_q <= '0;
      free_q    <= 1'b0;
      free_s_q  <= '0;
      lru_s_q   <= '0;
      lru_r_q   <= '0;
      vcnt_q    <= '0;
      tgt_q     <= '0;
      old_q     <= '0;
    end else begin
      case (state_q)
        lpcd_pkg::ST_IDLE: begin
          idx_q   <= '0;
          match_q <= 1'b0;
          free_q  <= 1'b0;
          lru_s_q <= '0;
          lru_r_q <= '0;
          vcnt_q  <= '0;
          any_q   <= 1'b0;
          cmd_q   <= cmd.data.command;
          pg_q    <= cmd.data.page_number;
        end
        lpcd_pkg::ST_SCAN: begin
          if (cur_match && !match_q) begin
            match_q <= 1'b1;
            match_s_q <= ix;
          end
          if (!cur_v && !free_q) begin
            free_q <= 1'b1;
            free_s_q <= ix;
          end
          if (cur_v) vcnt_q <= vcnt_q + 1'b1;
          if (idx_q != '0 && rank_q[ix] > lru_r_q) begin
            lru_r_q <= rank_q[ix];
            lru_s_q <= ix;
          end else if (idx_q == '0) lru_r_q <= rank_q[ix];
          idx_q <= walk_end ? '0 : idx_q + 1'b1;
        end
        lpcd_pkg::ST_DECIDE: begin
          if (is_gp) begin
            if (match_q) begin
              tgt_q <= match_s_q;
              old_q <= lpcd_pkg::CntW'(rank_q[match_s_q]);
              if (cmd_q == lpcd_pkg::CMD_PUT) dirty_q[match_s_q] <= 1'b1;
              else hits_q <= hits_q + 1'b1;
            end else begin
              tgt_q <= vic;
              old_q <= free_q ? vcnt_q : lpcd_pkg::CntW'(rank_q[vic]);
              if (cmd_q == lpcd_pkg::CMD_GET) miss_q <= miss_q + 1'b1;
              valid_q[vic] <= 1'b1;
              dirty_q[vic] <= (cmd_q == lpcd_pkg::CMD_PUT);
            end
          end else if (match_q) begin
            if (cmd_q == lpcd_pkg::CMD_MARK) dirty_q[match_s_q] <= 1'b1;
            else if (cmd_q == lpcd_pkg::CMD_FLUSH_PG) dirty_q[match_s_q] <= 1'b0;
          end
        end
        lpcd_pkg::ST_TOUCH: begin
          // valid bits already include the target; it is skipped
          if (ix == tgt_q) rank_q[ix] <= '0;
          else if (cur_v && lpcd_pkg::CntW'(rank_q[ix]) < old_q)
            rank_q[ix] <= rank_q[ix] + 1'b1;
          idx_q <= walk_end ? '0 : idx_q + 1'b1;
        end
        lpcd_pkg::ST_FLUSH: begin
          if (!(ovld_q && !res.ready)) begin
            if (fa_emit) begin
              dirty_q[ix] <= 1'b0;
              any_q       <= 1'b1;
            end
            idx_q <= walk_end ? '0 : idx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/sv/lru_page_cache_directory_test.sv
// Self-checking testbench for the LRU page cache directory.
`timescale 1ns / 1ps
module lru_page_cache_directory_test;

  localparam int unsigned MaxCycles = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  lpcd_cmd_if cmd_ch ();
  lpcd_res_if res_ch ();

  lru_page_cache_directory u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd_ch.sink),
    .res    (res_ch.source)
  );

  // Shadow copy of the directory state.
  logic [31:0]      dir_page [lpcd_pkg::Slots];
  logic             dir_valid[lpcd_pkg::Slots];
  logic             dir_dirty[lpcd_pkg::Slots];
  int unsigned      dir_rank [lpcd_pkg::Slots];
  logic [31:0]      hits_seen;
  logic [31:0]      misses_seen;

  lpcd_pkg::result_t pending_results[$];
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;

  // Idle percentages; sink_hold forces a long stall from its own process.
  int unsigned      send_idle_pct = 0;
  int unsigned      sink_idle_pct = 0;
  logic             sink_hold = 1'b0;

  // Pages already seen, to build hit-heavy traffic.
  logic [31:0]      page_pool[$];

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < lpcd_pkg::Slots; i++) begin
      dir_page[i] = '0; dir_valid[i] = 1'b0; dir_dirty[i] = 1'b0; dir_rank[i] = 0;
    end
    hits_seen = '0;
    misses_seen = '0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result sink: random ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !sink_hold && ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  function automatic lpcd_pkg::result_t blank_result();
    lpcd_pkg::result_t r;
    r = '0;
    r.hit_count  = hits_seen;
    r.miss_count = misses_seen;
    r.last       = 1'b1;
    return r;
  endfunction

  // Move slot s to the head; old_rank is its prior rank (valid count if new).
  function automatic void promote_slot(int s, int unsigned old_rank);
    for (int i = 0; i < lpcd_pkg::Slots; i++)
      if (i != s && dir_valid[i] && dir_rank[i] < old_rank) dir_rank[i]++;
    dir_rank[s] = 0;
  endfunction

  // Work out the results of one command and advance the shadow state.
  function automatic void predict_directory(logic [2:0] op, logic [31:0] page);
    lpcd_pkg::result_t r;
    int s;
    int n;
    int nvalid;
    s = -1;
    for (int i = lpcd_pkg::Slots - 1; i >= 0; i--)
      if (dir_valid[i] && dir_page[i] == page) s = i;
    case (op)
      lpcd_pkg::CMD_GET, lpcd_pkg::CMD_PUT: begin
        if (s >= 0) begin
          if (op == lpcd_pkg::CMD_GET) hits_seen++;
          else dir_dirty[s] = 1'b1;
          promote_slot(s, dir_rank[s]);
          r = blank_result();
          r.hit  = 1'b1;
          r.slot = s[3:0];
        end else begin
          if (op == lpcd_pkg::CMD_GET) misses_seen++;
          r = blank_result();
          nvalid = 0;
          for (int i = lpcd_pkg::Slots - 1; i >= 0; i--)
            if (!dir_valid[i]) s = i; else nvalid++;
          if (s >= 0) begin
            promote_slot(s, nvalid);
          end else begin
            s = 0;
            for (int i = 1; i < lpcd_pkg::Slots; i++)
              if (dir_rank[i] > dir_rank[s]) s = i;
            if (dir_dirty[s]) begin
              r.writeback_valid = 1'b1;
              r.writeback_page  = dir_page[s];
              r.writeback_slot  = s[3:0];
            end
            promote_slot(s, dir_rank[s]);
          end
          dir_page[s]   = page;
          dir_valid[s]  = 1'b1;
          dir_dirty[s]  = (op == lpcd_pkg::CMD_PUT);
          r.slot        = s[3:0];
          r.fill_needed = (op == lpcd_pkg::CMD_GET);
        end
        pending_results.push_back(r);
      end
      lpcd_pkg::CMD_FLUSH_PG, lpcd_pkg::CMD_MARK: begin
        r = blank_result();
        if (s >= 0) begin
          r.slot  = s[3:0];
          r.found = 1'b1;
          if (op == lpcd_pkg::CMD_MARK) begin
            dir_dirty[s] = 1'b1;
          end else if (dir_dirty[s]) begin
            dir_dirty[s]      = 1'b0;
            r.writeback_valid = 1'b1;
            r.writeback_page  = dir_page[s];
            r.writeback_slot  = s[3:0];
          end
        end
        pending_results.push_back(r);
      end
      lpcd_pkg::CMD_FLUSH_ALL: begin
        n = 0;
        for (int i = 0; i < lpcd_pkg::Slots; i++) begin
          if (dir_valid[i] && dir_dirty[i]) begin
            dir_dirty[i]      = 1'b0;
            r                 = blank_result();
            r.last            = 1'b0;
            r.slot            = i[3:0];
            r.writeback_valid = 1'b1;
            r.writeback_page  = dir_page[i];
            r.writeback_slot  = i[3:0];
            pending_results.push_back(r);
            n++;
          end
        end
        if (n == 0) pending_results.push_back(blank_result());
        else pending_results[$].last = 1'b1;
      end
      default: pending_results.push_back(blank_result());
    endcase
  endfunction

  // Result checker: every transfer against the oldest expectation.
  always @(posedge clk_i) begin
    lpcd_pkg::result_t want;
    lpcd_pkg::result_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer %p", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit exp %0h got %0h", want.hit, got.hit); error_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot exp %0h got %0h", want.slot, got.slot); error_count++;
        end
        if (got.found !== want.found) begin
          $error("found exp %0h got %0h", want.found, got.found); error_count++;
        end
        if (got.fill_needed !== want.fill_needed) begin
          $error("fill_needed exp %0h got %0h", want.fill_needed, got.fill_needed);
          error_count++;
        end
        if (got.writeback_valid !== want.writeback_valid) begin
          $error("writeback_valid exp %0h got %0h", want.writeback_valid,
                 got.writeback_valid);
          error_count++;
        end
        if (got.writeback_page !== want.writeback_page) begin
          $error("writeback_page exp %0h got %0h", want.writeback_page,
                 got.writeback_page);
          error_count++;
        end
        if (got.writeback_slot !== want.writeback_slot) begin
          $error("writeback_slot exp %0h got %0h", want.writeback_slot,
                 got.writeback_slot);
          error_count++;
        end
        if (got.hit_count !== want.hit_count) begin
          $error("hit_count exp %0h got %0h", want.hit_count, got.hit_count);
          error_count++;
        end
        if (got.miss_count !== want.miss_count) begin
          $error("miss_count exp %0h got %0h", want.miss_count, got.miss_count);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last exp %0h got %0h", want.last, got.last); error_count++;
        end
      end
    end
  end

  // Offer one command until its transfer; prediction happens at acceptance.
  // valid stays up after the transfer; an idle draw or the drain drops it.
  task automatic send_command(logic [2:0] op, logic [31:0] page);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= '{command: op, page_number: page};
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    predict_directory(op, page);
    if (page_pool.size() < 40) page_pool.push_back(page);
    else page_pool[$urandom_range(39, 0)] = page;
  endtask

  task automatic test_directed();
    // Fill with extremes, then evict; flush and mark on clean, dirty, absent.
    send_command(lpcd_pkg::CMD_FLUSH_ALL, 32'h0);
    send_command(lpcd_pkg::CMD_GET, 32'h0000_0000);
    send_command(lpcd_pkg::CMD_PUT, 32'hFFFF_FFFF);
    send_command(lpcd_pkg::CMD_GET, 32'hFFFF_FFFF);
    send_command(lpcd_pkg::CMD_PUT, 32'h0000_0000);
    send_command(lpcd_pkg::CMD_FLUSH_PG, 32'h0000_0000);
    send_command(lpcd_pkg::CMD_FLUSH_PG, 32'h0000_0000);
    send_command(lpcd_pkg::CMD_FLUSH_PG, 32'h1234_5678);
    send_command(lpcd_pkg::CMD_MARK, 32'h1234_5678);
    send_command(lpcd_pkg::CMD_MARK, 32'h0000_0000);
    send_command(3'd5, 32'hAAAA_5555);
    send_command(3'd7, 32'h5555_AAAA);
    for (int i = 2; i < 18; i++)
      send_command(i[0] ? lpcd_pkg::CMD_PUT : lpcd_pkg::CMD_GET, 32'h100 + i);
    send_command(lpcd_pkg::CMD_FLUSH_ALL, 32'h0);
    send_command(lpcd_pkg::CMD_FLUSH_ALL, 32'h0);
  endtask

  task automatic test_random(int unsigned count);
    logic [2:0]  op;
    logic [31:0] page;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) op = lpcd_pkg::CMD_GET;
      else if (pick < 70) op = lpcd_pkg::CMD_PUT;
      else if (pick < 80) op = lpcd_pkg::CMD_FLUSH_PG;
      else if (pick < 88) op = lpcd_pkg::CMD_MARK;
      else if (pick < 95) op = lpcd_pkg::CMD_FLUSH_ALL;
      else op = 3'($urandom_range(7, 5));
      if (page_pool.size() > 0 && $urandom_range(99, 0) < 65)
        page = page_pool[$urandom_range(page_pool.size() - 1, 0)];
      else page = $urandom();
      send_command(op, page);
    end
  endtask

  // Sink holds off for a long stretch while commands keep coming.
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      test_random(20);
    join
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 6;
    sink_idle_pct = 72;
    test_random(110);
    send_idle_pct = 72;
    sink_idle_pct = 6;
    test_random(110);
    send_idle_pct = 0;
    sink_idle_pct = 0;
    test_backpressure();
    test_random(110);
    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
